[hdl/hidx_pkg.sv]
// Shared constants and flow types for the Hilbert index pipeline.
package hidx_pkg;

  // Grid and fixed point format
  localparam int GRID_BITS = 16;
  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;
  localparam int RANGE_W   = 32;
  localparam int NUM_W     = COORD_W + GRID_BITS;
  localparam int IDX_W     = 2 * GRID_BITS;
  localparam int OUT_W     = 32;
  localparam int REG_IDX_W = 2;

  // Two front stages, one divide cell and one curve cell per grid bit
  localparam int LATENCY = 2 + 2 * GRID_BITS;

  localparam logic [GRID_BITS-1:0] GRID_TOP = '1;
  localparam logic [RANGE_W-1:0] UNIT_RANGE = RANGE_W'(64'd1 << FRAC_BITS);

  typedef enum logic [REG_IDX_W-1:0] {
    REG_MIN_X = 2'd0,
    REG_MAX_X = 2'd1,
    REG_MIN_Y = 2'd2,
    REG_MAX_Y = 2'd3
  } reg_idx_t;

  // Partial remainder, numerator bits still to shift in, quotient so far
  typedef struct packed {
    logic [RANGE_W-1:0]   rem;
    logic [GRID_BITS-1:0] num_lo;
    logic [GRID_BITS-1:0] quo;
    logic                 sat;
  } div_flow_t;

  // Grid coordinates (current level at the MSB) and distance so far
  typedef struct packed {
    logic [GRID_BITS-1:0] x;
    logic [GRID_BITS-1:0] y;
    logic [IDX_W-1:0]     acc;
  } curve_flow_t;

endpackage

[hdl/hidx_front.sv]
// Offset, clamp detection and scaled numerator for one axis.
module hidx_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic signed [hidx_pkg::COORD_W-1:0] coord,
  input  logic signed [hidx_pkg::COORD_W-1:0] lo,
  input  logic        [hidx_pkg::RANGE_W-1:0] range,
  output logic                                out_valid,
  output hidx_pkg::div_flow_t                 out_flow
);

  logic                                valid_a;
  logic signed [hidx_pkg::COORD_W:0]   off;
  logic signed [hidx_pkg::COORD_W:0]   off_next;
  logic        [hidx_pkg::NUM_W-1:0]   num;
  logic                                below;
  logic                                above;
  hidx_pkg::div_flow_t                 flow_next;

  // Exact 33-bit offset from the lower bound
  assign off_next = {coord[hidx_pkg::COORD_W-1], coord} - {lo[hidx_pkg::COORD_W-1], lo};

  // off * (2^G - 1) as shift and subtract
  always_comb begin
    below = (off <= 0);
    above = (off >= $signed({1'b0, range}));
    num   = ({hidx_pkg::NUM_W{1'b0}} | hidx_pkg::NUM_W'(off[hidx_pkg::COORD_W-1:0]))
            << hidx_pkg::GRID_BITS;
    num   = num - hidx_pkg::NUM_W'(off[hidx_pkg::COORD_W-1:0]);
    if (below || above) begin
      num = '0;
    end
    flow_next.rem    = num[hidx_pkg::NUM_W-1:hidx_pkg::GRID_BITS];
    flow_next.num_lo = num[hidx_pkg::GRID_BITS-1:0];
    flow_next.quo    = '0;
    flow_next.sat    = above && !below;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      valid_a   <= in_valid;
      out_valid <= valid_a;
    end
  end

  always_ff @(posedge clk) begin
    off      <= off_next;
    out_flow <= flow_next;
  end

endmodule

[hdl/hidx_div_cell.sv]
// One restoring division step: brings in one numerator bit, yields one quotient bit.
module hidx_div_cell (
  input  logic                                clk,
  input  logic                                rst,
  input  logic        [hidx_pkg::RANGE_W-1:0] range,
  input  logic                                in_valid,
  input  hidx_pkg::div_flow_t                 in_flow,
  output logic                                out_valid,
  output hidx_pkg::div_flow_t                 out_flow
);

  logic [hidx_pkg::RANGE_W:0] trial;
  logic [hidx_pkg::RANGE_W:0] diff;
  logic                       ge;
  hidx_pkg::div_flow_t        flow_next;

  // Compare and subtract against the divisor
  always_comb begin
    trial = {in_flow.rem, in_flow.num_lo[hidx_pkg::GRID_BITS-1]};
    diff  = trial - {1'b0, range};
    ge    = (trial >= {1'b0, range});
    flow_next.rem    = ge ? diff[hidx_pkg::RANGE_W-1:0] : trial[hidx_pkg::RANGE_W-1:0];
    flow_next.num_lo = {in_flow.num_lo[hidx_pkg::GRID_BITS-2:0], 1'b0};
    flow_next.quo    = {in_flow.quo[hidx_pkg::GRID_BITS-2:0], ge};
    flow_next.sat    = in_flow.sat;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_flow <= flow_next;
  end

endmodule

[hdl/hidx_curve_cell.sv]
// One level of the Hilbert recursion: quadrant digit, then rotate and reflect.
module hidx_curve_cell (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  hidx_pkg::curve_flow_t in_flow,
  output logic                  out_valid,
  output hidx_pkg::curve_flow_t out_flow
);

  logic                           rx;
  logic                           ry;
  logic [hidx_pkg::GRID_BITS-1:0] xs;
  logic [hidx_pkg::GRID_BITS-1:0] ys;
  hidx_pkg::curve_flow_t          flow_next;

  always_comb begin
    rx = in_flow.x[hidx_pkg::GRID_BITS-1];
    ry = in_flow.y[hidx_pkg::GRID_BITS-1];
    xs = in_flow.x;
    ys = in_flow.y;
    // Lower quadrants rotate; lower right also reflects
    if (!ry) begin
      if (rx) begin
        xs = ~in_flow.x;
        ys = ~in_flow.y;
      end
      {xs, ys} = {ys, xs};
    end
    // Digit (3*rx)^ry appended; next level moves to the MSB
    flow_next.acc = {in_flow.acc[hidx_pkg::IDX_W-3:0], rx, rx ^ ry};
    flow_next.x   = {xs[hidx_pkg::GRID_BITS-2:0], 1'b0};
    flow_next.y   = {ys[hidx_pkg::GRID_BITS-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_flow <= flow_next;
  end

endmodule

[hdl/hilbert_index_2d_normalized.sv]
// Top level: configuration registers, per-axis divider chains, Hilbert cell chain.
//
//  channel  | handshake        | payload
//  ---------+------------------+------------------------------------------
//  input    | start, busy      | point_x[31:0], point_y[31:0] (signed)
//  result   | done             | curve_index[31:0]
//  config   | wr_en            | wr_index[1:0], wr_data[31:0]
//
// One point per cycle; busy stays low. After its start, each result passes through
// the two front stages, then one divider cell per grid bit and, after the dividers,
// one curve cell per grid bit. Synchronous reset clears all valid flags and
// restores the bound registers. The receiver takes done without backpressure.
module hilbert_index_2d_normalized (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [hidx_pkg::COORD_W-1:0]   point_x,
  input  logic signed [hidx_pkg::COORD_W-1:0]   point_y,
  output logic                                  done,
  output logic        [hidx_pkg::OUT_W-1:0]     curve_index,
  input  logic                                  wr_en,
  input  logic        [hidx_pkg::REG_IDX_W-1:0] wr_index,
  input  logic        [hidx_pkg::COORD_W-1:0]   wr_data
);

  localparam int G = hidx_pkg::GRID_BITS;

  logic signed [hidx_pkg::COORD_W-1:0] min_x;
  logic signed [hidx_pkg::COORD_W-1:0] max_x;
  logic signed [hidx_pkg::COORD_W-1:0] min_y;
  logic signed [hidx_pkg::COORD_W-1:0] max_y;
  logic signed [hidx_pkg::COORD_W:0]   span_x;
  logic signed [hidx_pkg::COORD_W:0]   span_y;
  logic        [hidx_pkg::RANGE_W-1:0] range_x;
  logic        [hidx_pkg::RANGE_W-1:0] range_y;
  logic                                take;

  logic                  vx  [G+1];
  logic                  vy  [G+1];
  hidx_pkg::div_flow_t   dfx [G+1];
  hidx_pkg::div_flow_t   dfy [G+1];
  logic                  vc  [G+1];
  hidx_pkg::curve_flow_t cf  [G+1];

  assign busy = 1'b0;
  assign take = start && !busy;

  // Bound registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_x <= '0;
      max_x <= hidx_pkg::COORD_W'(hidx_pkg::UNIT_RANGE);
      min_y <= '0;
      max_y <= hidx_pkg::COORD_W'(hidx_pkg::UNIT_RANGE);
    end else if (wr_en) begin
      unique case (hidx_pkg::reg_idx_t'(wr_index))
        hidx_pkg::REG_MIN_X: min_x <= wr_data;
        hidx_pkg::REG_MAX_X: max_x <= wr_data;
        hidx_pkg::REG_MIN_Y: min_y <= wr_data;
        hidx_pkg::REG_MAX_Y: max_y <= wr_data;
        default: ;
      endcase
    end
  end

  // Axis ranges; empty or negative span falls back to 1.0
  always_comb begin
    span_x  = {max_x[hidx_pkg::COORD_W-1], max_x} - {min_x[hidx_pkg::COORD_W-1], min_x};
    span_y  = {max_y[hidx_pkg::COORD_W-1], max_y} - {min_y[hidx_pkg::COORD_W-1], min_y};
    range_x = (span_x <= 0) ? hidx_pkg::UNIT_RANGE : span_x[hidx_pkg::RANGE_W-1:0];
    range_y = (span_y <= 0) ? hidx_pkg::UNIT_RANGE : span_y[hidx_pkg::RANGE_W-1:0];
  end

  hidx_front u_front_x (
    .clk(clk), .rst(rst), .in_valid(take), .coord(point_x), .lo(min_x),
    .range(range_x), .out_valid(vx[0]), .out_flow(dfx[0])
  );

  hidx_front u_front_y (
    .clk(clk), .rst(rst), .in_valid(take), .coord(point_y), .lo(min_y),
    .range(range_y), .out_valid(vy[0]), .out_flow(dfy[0])
  );

  // Divider chains, one quotient bit per cell
  for (genvar i = 0; i < G; i++) begin : g_div
    hidx_div_cell u_div_x (
      .clk(clk), .rst(rst), .range(range_x), .in_valid(vx[i]), .in_flow(dfx[i]),
      .out_valid(vx[i+1]), .out_flow(dfx[i+1])
    );
    hidx_div_cell u_div_y (
      .clk(clk), .rst(rst), .range(range_y), .in_valid(vy[i]), .in_flow(dfy[i]),
      .out_valid(vy[i+1]), .out_flow(dfy[i+1])
    );
  end

  // Grid coordinates with top clamp applied
  always_comb begin
    vc[0]     = vx[G] && vy[G];
    cf[0].x   = dfx[G].sat ? hidx_pkg::GRID_TOP : dfx[G].quo;
    cf[0].y   = dfy[G].sat ? hidx_pkg::GRID_TOP : dfy[G].quo;
    cf[0].acc = '0;
  end

  // Hilbert chain, one level per cell, MSB level first
  for (genvar i = 0; i < G; i++) begin : g_curve
    hidx_curve_cell u_curve (
      .clk(clk), .rst(rst), .in_valid(vc[i]), .in_flow(cf[i]),
      .out_valid(vc[i+1]), .out_flow(cf[i+1])
    );
  end

  assign done        = vc[G];
  assign curve_index = hidx_pkg::OUT_W'(cf[G].acc);

endmodule

[hdl/hidx_checker.sv]
// Port-level checks on the Hilbert index block, bound to the top level.
module hidx_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // Never stalls the sender
  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  // Every transfer in yields a result after the fixed latency
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(hidx_pkg::LATENCY) done)
    else $error("result missing");

  // No result without a transfer in at the matching earlier cycle
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, hidx_pkg::LATENCY))
    else $error("spurious result");

  // Reset empties the pipeline
  a_reset_clears: assert property (@(posedge clk) rst |=> !done)
    else $error("result after reset");

endmodule

bind hilbert_index_2d_normalized hidx_checker u_hidx_checker (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done)
);
